FILE: sv/prbq_pkg.sv
// Shared types and constants for the process ready/blocked queue block.
// No dependencies; imported by the channel users, controller, datapath and top.
package prbq_pkg;

  // Field widths
  localparam int OP_W   = 3;
  localparam int ID_W   = 16;
  localparam int SIZE_W = 16;
  localparam int ST_W   = 3;
  localparam int TOT_W  = 5;

  // Default parameter values and register reset
  localparam int MAX_PROCS_DEF = 16;
  localparam int ID_BITS_DEF   = 16;
  localparam logic [SIZE_W-1:0] LIMIT_RESET = 16'd1024;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_BLOCK  = 3'd1;
  localparam logic [OP_W-1:0] OP_WAKE   = 3'd2;
  localparam logic [OP_W-1:0] OP_KILL   = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST   = 3'd4;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_BIG      = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  // Channel payloads
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   proc_id;
    logic [SIZE_W-1:0] proc_size;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   entry_id;
    logic [SIZE_W-1:0] entry_size;
    logic [TOT_W-1:0]  running_total;
    logic [TOT_W-1:0]  blocked_total;
    logic              last;
  } out_item_t;

  typedef logic [SIZE_W-1:0] cfg_item_t;

  // Scan index control
  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_INC,
    IDX_CLR
  } idx_cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic     in_ready;
    idx_cmd_t idx_cmd;
    logic     run_push;     // append to running tail, count up
    logic     run_src_new;  // running append takes the request, else blocked read data
    logic     blk_push;     // append running read data to blocked tail, count up
    logic     run_shift;    // running[idx-1] <= running[idx]
    logic     blk_shift;
    logic     run_pop;      // running count down
    logic     blk_pop;
    logic     out_load;
    logic     out_list;     // result carries the listed running entry
    status_t  status;
    logic     out_last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic            in_valid;
    logic [OP_W-1:0] op;
    logic            run_empty;
    logic            blk_empty;
    logic            run_end;
    logic            blk_end;
    logic            run_hit;
    logic            blk_hit;
    logic            run_full;
    logic            blk_full;
    logic            table_full;
    logic            too_big;
    logic            run_at_last;
    logic            out_free;
  } dp_status_t;

endpackage

FILE: sv/prbq_chan_if.sv
// Valid/ready channel interface carrying one payload of type data_t.
// Depends on nothing; payload types come from prbq_pkg at the instance.
interface prbq_chan_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/prbq_ctrl.sv
// Request sequencer: decodes the captured request and steps the datapath
// through scan, shift, list and response. Depends on prbq_pkg.
module prbq_ctrl
  import prbq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_SCAN_RUN,
    S_SCAN_BLK,
    S_SHIFT_RUN,
    S_SHIFT_BLK,
    S_LIST,
    S_RESP
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  // Next state, pending status and datapath commands
  always_comb begin
    state_nxt   = state_r;
    st_nxt      = st_r;
    cmd         = '0;
    cmd.idx_cmd = IDX_HOLD;
    cmd.status  = st_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.idx_cmd  = IDX_CLR;
        if (sts.in_valid) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        st_nxt = ST_OK;
        case (sts.op)
          OP_CREATE: state_nxt = S_SCAN_RUN;
          OP_BLOCK, OP_KILL: begin
            if (sts.run_empty) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_SCAN_RUN;
            end
          end
          OP_WAKE: begin
            if (sts.blk_empty) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_SCAN_BLK;
            end
          end
          OP_LIST: begin
            if (sts.run_empty) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_LIST;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      // One running entry compared per cycle
      S_SCAN_RUN: begin
        if (sts.run_end) begin
          if (sts.op == OP_CREATE) begin
            cmd.idx_cmd = IDX_CLR;
            state_nxt   = S_SCAN_BLK;
          end else begin
            st_nxt    = ST_NOTFOUND;
            state_nxt = S_RESP;
          end
        end else if (sts.run_hit) begin
          if (sts.op == OP_CREATE) begin
            st_nxt    = ST_DUP;
            state_nxt = S_RESP;
          end else begin
            cmd.blk_push = (sts.op == OP_BLOCK) && !sts.blk_full;
            cmd.idx_cmd  = IDX_INC;
            state_nxt    = S_SHIFT_RUN;
          end
        end else begin
          cmd.idx_cmd = IDX_INC;
        end
      end
      // One blocked entry compared per cycle
      S_SCAN_BLK: begin
        if (sts.blk_end) begin
          if (sts.op == OP_CREATE) begin
            if (sts.too_big) begin
              st_nxt = ST_BIG;
            end else if (sts.table_full) begin
              st_nxt = ST_FULL;
            end else begin
              cmd.run_push    = 1'b1;
              cmd.run_src_new = 1'b1;
            end
          end else begin
            st_nxt = ST_NOTFOUND;
          end
          state_nxt = S_RESP;
        end else if (sts.blk_hit) begin
          if (sts.op == OP_CREATE) begin
            st_nxt    = ST_DUP;
            state_nxt = S_RESP;
          end else begin
            cmd.run_push = !sts.run_full;
            cmd.idx_cmd  = IDX_INC;
            state_nxt    = S_SHIFT_BLK;
          end
        end else begin
          cmd.idx_cmd = IDX_INC;
        end
      end
      // Close the gap left by the removed entry
      S_SHIFT_RUN: begin
        if (sts.run_end) begin
          cmd.run_pop = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          cmd.run_shift = 1'b1;
          cmd.idx_cmd   = IDX_INC;
        end
      end
      S_SHIFT_BLK: begin
        if (sts.blk_end) begin
          cmd.blk_pop = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          cmd.blk_shift = 1'b1;
          cmd.idx_cmd   = IDX_INC;
        end
      end
      // One listed entry per transfer
      S_LIST: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_list = 1'b1;
          cmd.status   = ST_OK;
          cmd.out_last = sts.run_at_last;
          if (sts.run_at_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_cmd = IDX_INC;
          end
        end
      end
      S_RESP: begin
        cmd.out_last = 1'b1;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and pending status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

FILE: sv/prbq_dp.sv
// Datapath: request capture, running and blocked queue memories, counts,
// scan index, size limit register and result register. Depends on prbq_pkg
// and prbq_chan_if.
module prbq_dp
  import prbq_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  prbq_chan_if.sink   in_chan,
  prbq_chan_if.source out_chan,
  prbq_chan_if.sink   cfg_chan,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  sts
);

  localparam int SLOT_W = $clog2(MAX_PROCS);
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int SID_W  = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int ENT_W  = SID_W + SIZE_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

  logic [SIZE_W-1:0] limit_r;
  logic [OP_W-1:0]   op_r;
  logic [SID_W-1:0]  id_r;
  logic [SIZE_W-1:0] size_r;
  logic [CNT_W-1:0]  run_cnt_r, blk_cnt_r;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  idx_m1;
  logic [SLOT_W-1:0] raddr;

  // Queue order memories: each entry holds id and size
  logic [ENT_W-1:0]  run_mem [MAX_PROCS];
  logic [ENT_W-1:0]  blk_mem [MAX_PROCS];
  logic [ENT_W-1:0]  run_rd_r, blk_rd_r;

  logic              run_we, blk_we;
  logic [SLOT_W-1:0] run_waddr, blk_waddr;
  logic [ENT_W-1:0]  run_wdata, blk_wdata;

  out_item_t out_r;
  logic      out_valid_r;
  logic      in_fire;

  assign in_fire        = in_chan.valid & cmd.in_ready;
  assign in_chan.ready  = cmd.in_ready;
  assign cfg_chan.ready = 1'b1;

  // Size limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_chan.valid) begin
      limit_r <= cfg_chan.data;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_chan.data.op;
      id_r   <= in_chan.data.proc_id[SID_W-1:0];
      size_r <= in_chan.data.proc_size;
    end
  end

  // Scan index; memories are read at the next index so data matches idx_r
  always_comb begin
    case (cmd.idx_cmd)
      IDX_INC: idx_nxt = idx_r + 1'b1;
      IDX_CLR: idx_nxt = '0;
      default: idx_nxt = idx_r;
    endcase
  end
  assign raddr  = idx_nxt[SLOT_W-1:0];
  assign idx_m1 = idx_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // Write port selection
  assign run_we    = cmd.run_push | cmd.run_shift;
  assign run_waddr = cmd.run_push ? run_cnt_r[SLOT_W-1:0] : idx_m1[SLOT_W-1:0];
  assign run_wdata = cmd.run_shift   ? run_rd_r :
                     cmd.run_src_new ? {id_r, size_r} : blk_rd_r;
  assign blk_we    = cmd.blk_push | cmd.blk_shift;
  assign blk_waddr = cmd.blk_push ? blk_cnt_r[SLOT_W-1:0] : idx_m1[SLOT_W-1:0];
  assign blk_wdata = cmd.blk_shift ? blk_rd_r : run_rd_r;

  // Queue memories with registered read
  always_ff @(posedge clk) begin
    run_rd_r <= run_mem[raddr];
    blk_rd_r <= blk_mem[raddr];
    if (run_we) begin
      run_mem[run_waddr] <= run_wdata;
    end
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
  end

  // Queue lengths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
      blk_cnt_r <= '0;
    end else begin
      if (cmd.run_push) begin
        run_cnt_r <= run_cnt_r + 1'b1;
      end else if (cmd.run_pop) begin
        run_cnt_r <= run_cnt_r - 1'b1;
      end
      if (cmd.blk_push) begin
        blk_cnt_r <= blk_cnt_r + 1'b1;
      end else if (cmd.blk_pop) begin
        blk_cnt_r <= blk_cnt_r - 1'b1;
      end
    end
  end

  // Status toward the controller
  always_comb begin
    sts.in_valid    = in_chan.valid;
    sts.op          = op_r;
    sts.run_empty   = (run_cnt_r == '0);
    sts.blk_empty   = (blk_cnt_r == '0);
    sts.run_end     = (idx_r >= run_cnt_r);
    sts.blk_end     = (idx_r >= blk_cnt_r);
    sts.run_hit     = (run_rd_r[ENT_W-1:SIZE_W] == id_r);
    sts.blk_hit     = (blk_rd_r[ENT_W-1:SIZE_W] == id_r);
    sts.run_full    = (run_cnt_r == CNT_MAX);
    sts.blk_full    = (blk_cnt_r == CNT_MAX);
    sts.table_full  = ((CNT_W+1)'(run_cnt_r) + (CNT_W+1)'(blk_cnt_r))
                      >= (CNT_W+1)'(MAX_PROCS);
    sts.too_big     = (size_r >= limit_r);
    sts.run_at_last = ((CNT_W+1)'(idx_r) + 1'b1) == (CNT_W+1)'(run_cnt_r);
    sts.out_free    = !out_valid_r || out_chan.ready;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status        <= cmd.status;
      out_r.entry_id      <= cmd.out_list ? ID_W'(run_rd_r[ENT_W-1:SIZE_W]) : '0;
      out_r.entry_size    <= cmd.out_list ? run_rd_r[SIZE_W-1:0] : '0;
      out_r.running_total <= TOT_W'(run_cnt_r);
      out_r.blocked_total <= TOT_W'(blk_cnt_r);
      out_r.last          <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

endmodule

FILE: sv/process_ready_blocked_queues.sv
// Process table with ordered running and blocked queues; one request in flight at a time.
// Block, kill and wake scan the searched queue and close the gap on a hit; create scans
// both queues; list loads one entry per cycle while the result side is not stalled. The
// next request is accepted in the cycle after the last result load; a stalled result
// holds the sequencer.
// Reset (rst_n, synchronous, active low) empties both queues and loads the limit with 1024.
module process_ready_blocked_queues
  import prbq_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  prbq_chan_if.sink   in_chan,
  prbq_chan_if.source out_chan,
  prbq_chan_if.sink   cfg_chan
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequencer
  prbq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Queues, counts and result register
  prbq_dp #(
    .MAX_PROCS (MAX_PROCS),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

FILE: dv/process_ready_blocked_queues_test.sv
// Self-checking bench for process_ready_blocked_queues: a shadow of the process
// table predicts every result transfer; directed and random requests with idling.
// Depends on prbq_pkg, the prbq_chan_if interface and process_ready_blocked_queues.
module process_ready_blocked_queues_test
  import prbq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int POOL_N    = 20;
  localparam int SETTLE    = 2 * MAX_PROCS_DEF + 8;

  // Shadow of the process table; holds the results still owed by the block
  class queue_shadow;
    typedef struct {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
    } proc_rec_t;

    cfg_item_t limit;
    proc_rec_t run_q[$];
    proc_rec_t blk_q[$];
    out_item_t pending_results[$];
    int        mismatches;

    function new();
      limit = LIMIT_RESET;
      mismatches = 0;
    endfunction

    function int seek(proc_rec_t q[$], logic [ID_W-1:0] id);
      foreach (q[i]) if (q[i].id == id) return i;
      return -1;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function logic [ID_W-1:0] any_running(logic [ID_W-1:0] fallback);
      if (run_q.size() == 0) return fallback;
      return run_q[$urandom_range(0, run_q.size() - 1)].id;
    endfunction

    function logic [ID_W-1:0] any_blocked(logic [ID_W-1:0] fallback);
      if (blk_q.size() == 0) return fallback;
      return blk_q[$urandom_range(0, blk_q.size() - 1)].id;
    endfunction

    // Queue one expected result with the totals as they stand now
    function void post(status_t st, proc_rec_t rec, logic last_flag);
      out_item_t r;
      r.status        = st;
      r.entry_id      = rec.id;
      r.entry_size    = rec.size;
      r.running_total = TOT_W'(run_q.size());
      r.blocked_total = TOT_W'(blk_q.size());
      r.last          = last_flag;
      pending_results.push_back(r);
    endfunction

    // Apply one accepted request to the shadow and queue its results
    function void note_request(in_item_t req);
      status_t   st;
      proc_rec_t rec;
      proc_rec_t none;
      int        p;
      st = ST_OK;
      none = '{id: '0, size: '0};
      case (req.op)
        OP_CREATE: begin
          if (seek(run_q, req.proc_id) >= 0 || seek(blk_q, req.proc_id) >= 0) begin
            st = ST_DUP;
          end else if (req.proc_size >= limit) begin
            st = ST_BIG;
          end else if (run_q.size() + blk_q.size() >= MAX_PROCS_DEF) begin
            st = ST_FULL;
          end else begin
            rec = '{id: req.proc_id, size: req.proc_size};
            run_q.push_back(rec);
          end
        end
        OP_BLOCK, OP_KILL: begin
          p = seek(run_q, req.proc_id);
          if (run_q.size() == 0) begin
            st = ST_EMPTY;
          end else if (p < 0) begin
            st = ST_NOTFOUND;
          end else begin
            rec = run_q[p];
            run_q.delete(p);
            if (req.op == OP_BLOCK) blk_q.push_back(rec);
          end
        end
        OP_WAKE: begin
          p = seek(blk_q, req.proc_id);
          if (blk_q.size() == 0) begin
            st = ST_EMPTY;
          end else if (p < 0) begin
            st = ST_NOTFOUND;
          end else begin
            rec = blk_q[p];
            blk_q.delete(p);
            run_q.push_back(rec);
          end
        end
        OP_LIST: begin
          if (run_q.size() == 0) begin
            st = ST_EMPTY;
          end else begin
            foreach (run_q[i]) post(ST_OK, run_q[i], i == run_q.size() - 1);
            return;
          end
        end
        default: ;
      endcase
      post(st, none, 1'b1);
    endfunction

    function void compare(string field, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
        mismatches++;
      end
    endfunction

    // Check one result transfer against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h", $time, got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare("status", want.status, got.status);
      compare("entry_id", want.entry_id, got.entry_id);
      compare("entry_size", want.entry_size, got.entry_size);
      compare("running_total", want.running_total, got.running_total);
      compare("blocked_total", want.blocked_total, got.blocked_total);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  bit               idle_on;
  int               stall_left;
  logic [ID_W-1:0]  id_pool[POOL_N];
  queue_shadow      book;

  prbq_chan_if #(.data_t(in_item_t))  in_if ();
  prbq_chan_if #(.data_t(out_item_t)) out_if ();
  prbq_chan_if #(.data_t(cfg_item_t)) cfg_if ();

  process_ready_blocked_queues uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #4 clk = ~clk;

  // Result side: ready with random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else begin
      out_if.ready = 1'b1;
      if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 17);
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) book.check_result(out_if.data);
  end

  // Hard stop
  initial begin
    #8_000_000;
    $display("process_ready_blocked_queues verification failed");
    $finish;
  end

  // Size near or around the current limit, sometimes anything
  function automatic logic [SIZE_W-1:0] pick_size();
    cfg_item_t lim;
    int        r;
    lim = book.limit;
    r = $urandom_range(0, 9);
    if (r < 2) return SIZE_W'($urandom);
    if (r == 2) return lim;
    if (r == 3) return (lim == 0) ? '0 : lim - 1'b1;
    return (lim == 0) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, lim - 1));
  endfunction

  // Mostly well-formed requests against live ids, some noise
  function automatic in_item_t random_request();
    in_item_t        req;
    int              pick;
    logic [ID_W-1:0] pool_id;
    bit              aimed;
    pick = $urandom_range(0, 99);
    pool_id = id_pool[$urandom_range(0, POOL_N - 1)];
    aimed = $urandom_range(0, 6) != 0;
    req.op = OP_CREATE;
    req.proc_id = pool_id;
    req.proc_size = pick_size();
    if (pick < 34) begin
      req.op = OP_CREATE;
    end else if (pick < 50) begin
      req.op = OP_BLOCK;
      if (aimed) req.proc_id = book.any_running(pool_id);
    end else if (pick < 64) begin
      req.op = OP_WAKE;
      if (aimed) req.proc_id = book.any_blocked(pool_id);
    end else if (pick < 76) begin
      req.op = OP_KILL;
      if (aimed) req.proc_id = book.any_running(pool_id);
    end else if (pick < 90) begin
      req.op = OP_LIST;
    end else if (pick < 95) begin
      req.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end else begin
      req.op = OP_W'($urandom);
      req.proc_id = ID_W'($urandom);
      req.proc_size = SIZE_W'($urandom);
    end
    return req;
  endfunction

  // Offer one request; valid stays high into the next one unless a gap follows
  task automatic push_request(input in_item_t req);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data = req;
    do @(posedge clk); while (!in_if.ready);
    book.note_request(req);
  endtask

  task automatic request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                         input logic [SIZE_W-1:0] size);
    in_item_t req;
    req.op = op;
    req.proc_id = id;
    req.proc_size = size;
    push_request(req);
  endtask

  // Stop sending and let every owed result come back
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Size limit write, only with the block idle
  task automatic write_limit(input cfg_item_t lim);
    drain();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data = lim;
    do @(posedge clk); while (!cfg_if.ready);
    book.limit = lim;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic random_phase(input cfg_item_t lim, input int count, input int drain_at);
    write_limit(lim);
    for (int i = 0; i < count; i++) begin
      if (i == drain_at) drain();
      push_request(random_request());
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    idle_on = 1'b1;
    stall_left = 0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    book = new();
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) id_pool[i] = ID_W'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty queues, spare opcodes, create checks, missing ids
    request(OP_LIST, 16'h0000, 16'h0000);
    request(OP_BLOCK, 16'h0000, 16'hFFFF);
    request(OP_WAKE, 16'h0000, 16'h0000);
    request(OP_KILL, 16'hFFFF, 16'h0000);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      request(OP_W'(op), 16'hFFFF, 16'hFFFF);
    request(OP_CREATE, 16'h0000, 16'h0000);
    request(OP_CREATE, 16'h0000, 16'h0005);
    request(OP_CREATE, 16'hFFFF, LIMIT_RESET);
    request(OP_CREATE, 16'hFFFF, LIMIT_RESET - 1'b1);
    request(OP_CREATE, 16'h1234, 16'hFFFF);
    request(OP_BLOCK, 16'hFFFF, 16'h0000);
    request(OP_CREATE, 16'hFFFF, 16'h0001);
    request(OP_BLOCK, 16'h7777, 16'h0000);
    request(OP_WAKE, 16'h7777, 16'h0000);
    request(OP_KILL, 16'hFFFF, 16'h0000);
    request(OP_WAKE, 16'hFFFF, 16'h0000);
    request(OP_LIST, 16'h0000, 16'h0000);
    request(OP_KILL, 16'h0000, 16'h0000);
    // Fill the table past capacity, then list all of it
    for (int k = 0; k < MAX_PROCS_DEF; k++)
      request(OP_CREATE, ID_W'(16'h0100 + k), SIZE_W'(k * 64));
    request(OP_LIST, 16'h0000, 16'h0000);
    request(OP_BLOCK, 16'hFFFF, 16'h0000);
    request(OP_CREATE, 16'h4242, 16'h0003);

    // Random phases across limit settings, extremes included
    random_phase(16'hFFFF, 110, -1);
    random_phase(16'h0000, 40, -1);
    random_phase(16'h0001, 50, -1);
    random_phase(16'd300, 130, 65);
    idle_on = 1'b0;
    random_phase(16'hFFFF, 91, -1);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("process_ready_blocked_queues verification clean");
    end else begin
      $display("process_ready_blocked_queues verification failed");
    end
    $finish;
  end

endmodule
